/* rtl/sdi12rx_pkg.sv */
// Package for the SDI-12 response receiver: receiver modes, error codes,
// frame timing constants and the result word layout.
// No dependencies.
package sdi12rx_pkg;

  // Receiver mode: idle, waiting for a start bit, or inside a character.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_RECV = 2'd2
  } rx_mode_t;

  // Error codes reported with the end of a response.
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TIMEOUT  = 3'd1,
    ERR_STOP     = 3'd2,
    ERR_PARITY   = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_code_t;

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_MAXLEN  = 1'b1;

  localparam int unsigned MAX_CHARS = 64;

  // Half-bit tick positions within a character, counted from the start bit.
  localparam logic [4:0] FIRST_SAMPLE = 5'd3;
  localparam logic [4:0] LAST_SAMPLE  = 5'd17;
  localparam logic [4:0] STOP_SAMPLE  = 5'd19;

  localparam logic [6:0] CHAR_CR = 7'h0D;

  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd2400;
  localparam logic [6:0]  MAXLEN_RESET   = 7'd64;
  localparam logic [6:0]  CHAR_LIMIT_CAP = 7'(MAX_CHARS);

  // One result word.
  typedef struct packed {
    err_code_t  error_code;
    logic       done_res;
    logic [5:0] char_index;
    logic [6:0] char_code;
    logic       char_valid;
  } result_t;

endpackage

/* rtl/sdi12_response_receiver.sv */
// SDI-12 response receiver top level: tick-by-tick UART decode, 7E1, inverted line.
// Depends on sdi12rx_pkg.
//
// The block decodes an SDI-12 sensor response from a stream of sampled line
// levels, one input word per half-bit tick. Each input word is handled in the
// cycle it is accepted: the receiver state and the result register update on
// that same edge, so one word is taken every clock cycle (rate of one word per
// cycle) as long as the result register is empty or is being drained; the only
// stall comes from a result word that waits on m_tready. A begin request starts
// a read and clears the character count and the elapsed-tick timer. While waiting
// for a start bit the block reports a timeout once more than timeout_ticks ticks
// have gone by since a begin request. Within a character the data bits are sampled
// 3, 5, ..., 17 ticks after the start tick (LSB first, seven data bits and even
// parity) and the stop bit at tick 19. Every good character comes out as one
// result word with its position and m_tuser set; a carriage return, a bad stop
// bit, a parity mismatch or too many characters end the response with one word
// that has m_tlast set and carries the matching error code. Ticks that produce
// nothing emit no result word.
module sdi12_response_receiver
  import sdi12rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] begin_req, [1] line_level, [7:2] zero
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] char_code, [12:7] char_index,
                                 // [15:13] error_code
  output logic        m_tlast,   // done_res: the response ends with this word
  output logic        m_tuser,   // [0] char_valid: the word carries a character
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [15:0] timeout_ticks;
  logic [6:0]  max_length;

  // Receiver state.
  rx_mode_t    rx_mode, rx_mode_next;
  logic [4:0]  tick_phase, tick_phase_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [6:0]  char_count, char_count_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  // Result register.
  result_t     result, result_next;
  logic        result_hit;

  logic        s_fire;
  logic        begin_req;
  logic        line_level;

  // Working values after a begin request has been applied.
  rx_mode_t    mode_cur;
  logic [4:0]  phase_cur;
  logic [7:0]  shift_cur;
  logic [6:0]  count_cur;
  logic [15:0] elapsed_cur;
  logic [15:0] elapsed_inc;
  logic [4:0]  phase_inc;
  logic [6:0]  char_limit;
  logic [6:0]  rx_char;
  logic        parity_ok;

  assign begin_req  = s_tdata[0];
  assign line_level = s_tdata[1];

  // The result register is free when empty or being drained this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  assign m_tdata  = {result.error_code, result.char_index, result.char_code};
  assign m_tlast  = result.done_res;
  assign m_tuser  = result.char_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_length    <= MAXLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        CFG_MAXLEN:  max_length    <= cfg_data[6:0];
        default:     timeout_ticks <= timeout_ticks;
      endcase
    end
  end

  // The effective character limit is the smaller of max_length and the cap.
  assign char_limit = (max_length < CHAR_LIMIT_CAP) ? max_length : CHAR_LIMIT_CAP;

  always_comb begin
    mode_cur    = begin_req ? MODE_WAIT : rx_mode;
    phase_cur   = begin_req ? 5'd0  : tick_phase;
    shift_cur   = begin_req ? 8'd0  : shift_byte;
    count_cur   = begin_req ? 7'd0  : char_count;
    elapsed_cur = begin_req ? 16'd0 : elapsed_ticks;

    elapsed_inc = (elapsed_cur < ELAPSED_MAX) ? elapsed_cur + 16'd1 : elapsed_cur;
    phase_inc   = phase_cur + 5'd1;
    rx_char     = shift_cur[6:0];
    parity_ok   = (^rx_char) == shift_cur[7];

    rx_mode_next       = mode_cur;
    tick_phase_next    = phase_cur;
    shift_byte_next    = shift_cur;
    char_count_next    = count_cur;
    elapsed_ticks_next = elapsed_cur;
    result_hit         = 1'b0;
    result_next        = '0;

    unique case (mode_cur)
      MODE_WAIT: begin
        if (line_level) begin
          // Start bit seen: the character timing counts from this tick.
          rx_mode_next       = MODE_RECV;
          tick_phase_next    = 5'd0;
          shift_byte_next    = 8'd0;
          elapsed_ticks_next = elapsed_inc;
        end else if (elapsed_cur > timeout_ticks) begin
          rx_mode_next           = MODE_IDLE;
          result_hit             = 1'b1;
          result_next.done_res   = 1'b1;
          result_next.error_code = ERR_TIMEOUT;
        end else begin
          elapsed_ticks_next = elapsed_inc;
        end
      end
      MODE_RECV: begin
        elapsed_ticks_next = elapsed_inc;
        tick_phase_next    = phase_inc;
        if (phase_inc >= FIRST_SAMPLE && phase_inc <= LAST_SAMPLE && phase_inc[0]) begin
          // Data bit: a high line is a zero bit; shift in from the top, LSB first.
          shift_byte_next = {~line_level, shift_cur[7:1]};
        end else if (phase_inc == STOP_SAMPLE) begin
          rx_mode_next         = MODE_IDLE;
          result_hit           = 1'b1;
          result_next.done_res = 1'b1;
          priority if (line_level) begin
            result_next.error_code = ERR_STOP;
          end else if (!parity_ok) begin
            result_next.error_code = ERR_PARITY;
          end else if (count_cur >= char_limit) begin
            result_next.error_code = ERR_OVERFLOW;
          end else if (rx_char == CHAR_CR) begin
            result_next.error_code = ERR_NONE;
          end else begin
            // Good character: deliver it and wait for the next start bit.
            result_next.done_res   = 1'b0;
            result_next.error_code = ERR_NONE;
            result_next.char_valid = 1'b1;
            result_next.char_code  = rx_char;
            result_next.char_index = count_cur[5:0];
            char_count_next        = count_cur + 7'd1;
            rx_mode_next           = MODE_WAIT;
            tick_phase_next        = 5'd0;
          end
        end
      end
      default: begin
        rx_mode_next = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode       <= MODE_IDLE;
      tick_phase    <= 5'd0;
      shift_byte    <= 8'd0;
      char_count    <= 7'd0;
      elapsed_ticks <= 16'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s_fire) begin
        rx_mode       <= rx_mode_next;
        tick_phase    <= tick_phase_next;
        shift_byte    <= shift_byte_next;
        char_count    <= char_count_next;
        elapsed_ticks <= elapsed_ticks_next;
        m_tvalid      <= result_hit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by m_tvalid.
  always_ff @(posedge clk) begin
    if (s_fire && result_hit) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A waiting result word must block new input words.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result word stalled");

  // A delivered character never carries end of response or an error.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.char_valid) |-> (!result.done_res && result.error_code == ERR_NONE))
    else $error("character word with done or error set");

  // Every result word is either a character or the end of the response.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.char_valid != result.done_res))
    else $error("result word is neither character nor end");

  // Inside a character the phase never reaches the stop sample while stored.
  assert property (@(posedge clk) disable iff (rst)
    (rx_mode == MODE_RECV) |-> (tick_phase < STOP_SAMPLE))
    else $error("tick phase ran past the stop bit");

  // The character count never exceeds the cap.
  assert property (@(posedge clk) disable iff (rst)
    char_count <= CHAR_LIMIT_CAP)
    else $error("character count beyond cap");
`endif

endmodule
